>>> src/bda_pkg.sv
// Shared types and constants for the binary to decimal ASCII unit.
// No dependencies; used by bda_ctrl, bda_dp and the top level.
`default_nettype none
package bda_pkg;

    localparam int NUM_BITS  = 64;
    localparam int DIGIT_W   = 4;
    localparam int BITCNT_W  = $clog2(NUM_BITS + 1);
    localparam int ASCII_W   = 6;

    localparam logic [ASCII_W-1:0]  ASCII_ZERO = 6'd48;
    localparam logic [DIGIT_W-1:0]  ADD3_LIMIT = 4'd5;
    localparam logic [DIGIT_W-1:0]  ADD3_VALUE = 4'd3;

    // controller -> datapath
    typedef struct packed {
        logic load;        // capture number, clear BCD register
        logic dabble;      // one add-3 and shift step
        logic skip;        // drop a leading zero digit
        logic emit;        // register top digit as a beat and shift
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic bits_done;   // last binary bit is being shifted in
        logic top_zero;    // top BCD digit is zero
        logic digit_last;  // one digit left in the register
    } t_dp_status;

endpackage
`default_nettype wire

>>> src/bda_dp.sv
// Datapath: binary shift register, BCD double dabble register, counters
// and the output beat registers. Depends on bda_pkg.
`default_nettype none
module bda_dp #(
    parameter int MAX_DIGITS = 20
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic [bda_pkg::NUM_BITS-1:0]       i_number,
    input  wire bda_pkg::t_dp_cmd                   i_cmd,
    output bda_pkg::t_dp_status                     o_status,
    output logic [bda_pkg::ASCII_W-1:0]             o_ascii_digit,
    output logic                                    o_last_digit
);

    localparam int BCD_W   = MAX_DIGITS * bda_pkg::DIGIT_W;
    localparam int DCNT_W  = $clog2(MAX_DIGITS + 1);
    localparam logic [DCNT_W-1:0] DCNT_LOAD = DCNT_W'(MAX_DIGITS);
    localparam logic [DCNT_W-1:0] DCNT_ONE  = DCNT_W'(1);
    localparam logic [bda_pkg::BITCNT_W-1:0] BCNT_LOAD =
        bda_pkg::BITCNT_W'(bda_pkg::NUM_BITS);
    localparam logic [bda_pkg::BITCNT_W-1:0] BCNT_ONE = bda_pkg::BITCNT_W'(1);

    logic [bda_pkg::NUM_BITS-1:0]   r_bin;
    logic [BCD_W-1:0]               r_bcd;
    logic [BCD_W-1:0]               n_bcd_adj;
    logic [bda_pkg::BITCNT_W-1:0]   r_bit_cnt;
    logic [DCNT_W-1:0]              r_dig_cnt;
    logic [bda_pkg::ASCII_W-1:0]    r_ascii;
    logic                           r_last;
    logic [bda_pkg::DIGIT_W-1:0]    top_digit;

    // add 3 to every digit of 5 or more before the shift
    always_comb begin
        for (int i = 0; i < MAX_DIGITS; i++) begin
            logic [bda_pkg::DIGIT_W-1:0] d;
            d = r_bcd[i*bda_pkg::DIGIT_W +: bda_pkg::DIGIT_W];
            n_bcd_adj[i*bda_pkg::DIGIT_W +: bda_pkg::DIGIT_W] =
                (d >= bda_pkg::ADD3_LIMIT) ? d + bda_pkg::ADD3_VALUE : d;
        end
    end

    assign top_digit = r_bcd[BCD_W-1 -: bda_pkg::DIGIT_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_cnt <= '0;
            r_dig_cnt <= '0;
        end else if (i_cmd.load) begin
            r_bin     <= i_number;
            r_bcd     <= '0;
            r_bit_cnt <= BCNT_LOAD;
            r_dig_cnt <= DCNT_LOAD;
        end else if (i_cmd.dabble) begin
            r_bin     <= {r_bin[bda_pkg::NUM_BITS-2:0], 1'b0};
            // carry out of the top digit is dropped
            r_bcd     <= {n_bcd_adj[BCD_W-2:0], r_bin[bda_pkg::NUM_BITS-1]};
            r_bit_cnt <= r_bit_cnt - BCNT_ONE;
        end else if (i_cmd.skip || i_cmd.emit) begin
            r_bcd     <= {r_bcd[BCD_W-bda_pkg::DIGIT_W-1:0], {bda_pkg::DIGIT_W{1'b0}}};
            r_dig_cnt <= r_dig_cnt - DCNT_ONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_ascii <= bda_pkg::ASCII_ZERO + {2'b00, top_digit};
            r_last  <= (r_dig_cnt == DCNT_ONE);
        end
    end

    assign o_status.bits_done  = (r_bit_cnt == BCNT_ONE);
    assign o_status.top_zero   = (top_digit == '0);
    assign o_status.digit_last = (r_dig_cnt == DCNT_ONE);
    assign o_ascii_digit       = r_ascii;
    assign o_last_digit        = r_last;

endmodule
`default_nettype wire

>>> src/bda_ctrl.sv
// Controller: sequences load, conversion, leading-zero skip and emission.
// Depends on bda_pkg.
`default_nettype none
module bda_ctrl (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_start,
    input  wire bda_pkg::t_dp_status    i_status,
    output bda_pkg::t_dp_cmd            o_cmd,
    output logic                        o_busy,
    output logic                        o_strobe
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_EMIT
    } t_state;

    t_state r_state;
    logic   r_strobe;

    always_comb begin
        o_cmd        = '0;
        o_cmd.load   = (r_state == ST_IDLE) && i_start;
        o_cmd.dabble = (r_state == ST_CONV);
        o_cmd.skip   = (r_state == ST_SKIP) && i_status.top_zero && !i_status.digit_last;
        o_cmd.emit   = (r_state == ST_EMIT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= (r_state == ST_EMIT);
            case (r_state)
                ST_IDLE: begin
                    if (i_start) r_state <= ST_CONV;
                end
                ST_CONV: begin
                    if (i_status.bits_done) r_state <= ST_SKIP;
                end
                ST_SKIP: begin
                    // stop at the first nonzero digit, or keep the units digit
                    if (!i_status.top_zero || i_status.digit_last) r_state <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (i_status.digit_last) r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_busy   = (r_state != ST_IDLE) || !i_rst_n;
    assign o_strobe = r_strobe;

endmodule
`default_nettype wire

>>> src/binary_to_decimal_ascii_unit.sv
// Binary to decimal ASCII unit: 64-bit number in, ASCII digits out, MSD first.
// Busy after a start until the last digit is registered; a new number is taken only when idle.
// Steps: 64 double dabble shifts, one skip per suppressed leading zero, one emit per beat.
// The first beat follows the skip of leading zeros; beats are consecutive.
// Synchronous active-low reset returns to idle; the receiver cannot stall.
// Depends on bda_pkg, bda_ctrl, bda_dp.
`default_nettype none
module binary_to_decimal_ascii_unit #(
    parameter int MAX_DIGITS = 20
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [bda_pkg::NUM_BITS-1:0]   i_number,
    output logic                                o_strobe,
    output logic [bda_pkg::ASCII_W-1:0]         o_ascii_digit,
    output logic                                o_last_digit
);

    bda_pkg::t_dp_cmd    cmd;
    bda_pkg::t_dp_status status;

    bda_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy),
        .o_strobe (o_strobe)
    );

    bda_dp #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_number      (i_number),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_ascii_digit (o_ascii_digit),
        .o_last_digit  (o_last_digit)
    );

endmodule
`default_nettype wire

>>> tb/sv/bda_scoreboard.sv
// Scoreboard for the binary to decimal ASCII unit: predicts the digit beats of
// every accepted number and checks each output beat in order.
// Depends on bda_pkg.
module bda_scoreboard #(
    parameter int MAX_DIGITS = 20
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic                               i_busy,
    input  logic [bda_pkg::NUM_BITS-1:0]       i_number,
    input  logic                               i_strobe,
    input  logic [bda_pkg::ASCII_W-1:0]        i_ascii_digit,
    input  logic                               i_last_digit,
    output int                                 o_fail_count,
    output int                                 o_pending
);

    typedef logic [bda_pkg::NUM_BITS-1:0] t_number;
    typedef logic [bda_pkg::DIGIT_W-1:0]  t_digit;
    typedef logic [bda_pkg::ASCII_W-1:0]  t_ascii;

    localparam t_number DECIMAL_BASE = 10;

    typedef struct packed {
        t_ascii ascii_digit;
        logic   last_digit;
    } t_char_beat;

    t_char_beat expected_chars[$];
    t_char_beat head;

    // Digits of number mod 10^MAX_DIGITS, MSD first, leading zeros dropped.
    function automatic void queue_decimal_chars(input t_number number);
        t_digit     digits [MAX_DIGITS];
        t_number    rest;
        int         top;
        t_char_beat beat;
        rest = number;
        for (int k = 0; k < MAX_DIGITS; k++) begin
            digits[k] = t_digit'(rest % DECIMAL_BASE);
            rest      = rest / DECIMAL_BASE;
        end
        top = 0;
        for (int k = 1; k < MAX_DIGITS; k++) begin
            if (digits[k] != 0) begin
                top = k;
            end
        end
        for (int k = top; k >= 0; k--) begin
            beat.ascii_digit = bda_pkg::ASCII_ZERO + t_ascii'(digits[k]);
            beat.last_digit  = (k == 0);
            expected_chars.push_back(beat);
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_strobe) begin
                if (expected_chars.size() == 0) begin
                    $display("%0t: unexpected beat: expected none, actual %0d last=%0b",
                             $time, i_ascii_digit, i_last_digit);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    head = expected_chars.pop_front();
                    if (i_ascii_digit !== head.ascii_digit) begin
                        $display("%0t: ascii_digit mismatch: expected %0d, actual %0d",
                                 $time, head.ascii_digit, i_ascii_digit);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (i_last_digit !== head.last_digit) begin
                        $display("%0t: last_digit mismatch: expected %0b, actual %0b",
                                 $time, head.last_digit, i_last_digit);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
            if (i_start && !i_busy) begin
                queue_decimal_chars(i_number);
            end
        end
        o_pending = expected_chars.size();
    end

endmodule

>>> tb/sv/tb_binary_to_decimal_ascii_unit.sv
// Top of the binary to decimal ASCII unit testbench: clock, reset, number
// stimulus in bursts and the final verdict. Depends on bda_pkg, bda_scoreboard
// and the unit itself.
module tb_binary_to_decimal_ascii_unit;

    typedef logic [bda_pkg::NUM_BITS-1:0] t_number;

    localparam int MAX_DIGITS   = 20;
    localparam int RANDOM_ITEMS = 480;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int SETTLE_CYCLES = 100;
    localparam t_number DECIMAL_BASE = 10;

    logic                         i_clk;
    logic                         i_rst_n = 1'b0;
    logic                         start = 1'b0;
    logic                         busy;
    t_number                      i_number = '0;
    logic                         o_strobe;
    logic [bda_pkg::ASCII_W-1:0]  o_ascii_digit;
    logic                         o_last_digit;
    int                           fail_count;
    int                           pending;
    int                           items_sent;
    int                           burst_len;
    int                           gap;

    // extremes, digit-count boundaries, internal zeros, alternating bits
    t_number directed_numbers [17] = '{
        64'd0, 64'd1, 64'd9, 64'd10, 64'd99, 64'd100, 64'd1000000001,
        64'd1000000000000000000, 64'd9999999999999999999,
        64'd10000000000000000000, 64'd10000000000000000001,
        64'd12345678901234567890, 64'hFFFF_FFFF_FFFF_FFFF,
        64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
        64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA
    };

    binary_to_decimal_ascii_unit #(
        .MAX_DIGITS(MAX_DIGITS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_number     (i_number),
        .o_strobe     (o_strobe),
        .o_ascii_digit(o_ascii_digit),
        .o_last_digit (o_last_digit)
    );

    bda_scoreboard #(
        .MAX_DIGITS(MAX_DIGITS)
    ) u_scoreboard (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_number     (i_number),
        .i_strobe     (o_strobe),
        .i_ascii_digit(o_ascii_digit),
        .i_last_digit (o_last_digit),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Called at a rising edge; returns at the edge that accepts the number.
    // busy is sampled mid-cycle, where it is stable.
    task automatic send_number(input t_number value);
        i_number <= value;
        start    <= 1'b1;
        do @(negedge i_clk); while (busy);
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        int waited;
        waited = 0;
        @(negedge i_clk);
        while (pending != 0 && waited < DRAIN_LIMIT) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_number random_number();
        t_number value;
        t_number power;
        int      width;
        case ($urandom_range(0, 5))
            0: value = {$urandom, $urandom};
            1: begin
                width = $urandom_range(1, bda_pkg::NUM_BITS);
                value = {$urandom, $urandom} >> (bda_pkg::NUM_BITS - width);
            end
            2: begin
                // neighbors of a power of ten, where the digit count changes
                power = 1;
                repeat ($urandom_range(1, 19)) power = power * DECIMAL_BASE;
                value = power + t_number'($urandom_range(0, 4)) - 2;
            end
            3: value = t_number'($urandom_range(0, 999));
            4: value = '1 - t_number'($urandom_range(0, 1000));
            default: begin
                // up to 19 digits, about half of them zero
                value = '0;
                repeat (19) begin
                    value = value * DECIMAL_BASE
                          + (($urandom_range(0, 1) == 1) ? t_number'($urandom_range(1, 9))
                                                         : '0);
                end
            end
        endcase
        return value;
    endfunction

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_numbers[i]) begin
            send_number(directed_numbers[i]);
        end
        start <= 1'b0;
        wait_drained();

        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            burst_len = $urandom_range(1, 12);
            for (int b = 0; b < burst_len && items_sent < RANDOM_ITEMS; b++) begin
                send_number(random_number());
                items_sent++;
                if (items_sent == RANDOM_ITEMS / 2) begin
                    start <= 1'b0;
                    wait_drained();
                end
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 100);
            // a zero gap keeps start high into the next burst
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        start <= 1'b0;
        wait_drained();

        if (fail_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            if (pending != 0) begin
                $display("%0t: expected %0d more beats, actual none", $time, pending);
            end
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

>>> binary_to_decimal_ascii_unit.f
src/bda_pkg.sv
src/bda_dp.sv
src/bda_ctrl.sv
src/binary_to_decimal_ascii_unit.sv
tb/sv/bda_scoreboard.sv
tb/sv/tb_binary_to_decimal_ascii_unit.sv
